// ----- hdl/i2cem_pkg.sv -----
// ---------------------------------------------------------------------------
// i2cem_pkg
// Shared types, codes and constants of the I2C EEPROM master.
// ---------------------------------------------------------------------------
package i2cem_pkg;

    localparam int unsigned PAGE_BYTES  = 8;   // largest accepted page write
    localparam int unsigned BUF_SLOTS   = 8;   // write buffer depth
    localparam int unsigned BUF_IDX_W   = 3;   // index width into the buffer
    localparam int unsigned QUEUE_DEPTH = 2;   // front-to-back queue, power of two
    localparam int unsigned IN_TDATA_W  = 32;
    localparam int unsigned OUT_TDATA_W = 16;
    localparam int unsigned CFG_IDX_W   = 2;

    localparam logic [7:0] DEV_WR_ADDR_RST = 8'hA0;
    localparam logic [7:0] DEV_RD_ADDR_RST = 8'hA1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_WR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_RD = 2'd1;

    // input item function codes
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_LOAD  = 2'd1;
    localparam logic [1:0] FUNC_WRITE = 2'd2;
    localparam logic [1:0] FUNC_READ  = 2'd3;

    typedef enum logic [1:0] {
        KIND_TICK,
        KIND_LOAD,
        KIND_WRITE,
        KIND_READ
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_SEND,
        PH_RACK,
        PH_RECV,
        PH_MACK,
        PH_RESTART,
        PH_STOP
    } t_phase;

    typedef enum logic [1:0] {
        ST_DEVW,
        ST_MEM,
        ST_DATA,
        ST_DEVR
    } t_stage;

    typedef enum logic [2:0] {
        ERR_OK,
        ERR_NACK_DEVW,
        ERR_NACK_MEM,
        ERR_NACK_DATA,
        ERR_NACK_DEVR,
        ERR_TOO_LONG
    } t_err;

    // classified item, front to back
    typedef struct packed {
        t_kind                kind;
        logic                 too_long;
        logic                 sda_in;
        logic [7:0]           mem_addr;
        logic [7:0]           length;
        logic [BUF_IDX_W-1:0] buf_index;
        logic [7:0]           write_byte;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic [7:0] read_data;
        logic       read_valid;
        logic       last_read;
        logic       done_res;
        t_err       error_code;
    } t_res;

    // configuration write
    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [7:0]           data;
    } t_cfg_wr;

    function automatic t_err nack_err(input t_stage stage);
        t_err e;
        unique case (stage)
            ST_DEVW: e = ERR_NACK_DEVW;
            ST_MEM:  e = ERR_NACK_MEM;
            ST_DATA: e = ERR_NACK_DATA;
            ST_DEVR: e = ERR_NACK_DEVR;
        endcase
        return e;
    endfunction

endpackage

// ----- hdl/i2cem_front.sv -----
// ---------------------------------------------------------------------------
// i2cem_front
// Accepts input items, decodes the function code and flags oversize writes.
// ---------------------------------------------------------------------------
module i2cem_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_func,
    input  logic [i2cem_pkg::IN_TDATA_W-1:0] i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output i2cem_pkg::t_cmd               o_cmd
);
    import i2cem_pkg::*;

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    always_comb begin
        n_cmd.sda_in     = i_data[0];
        n_cmd.mem_addr   = i_data[8:1];
        n_cmd.length     = i_data[16:9];
        n_cmd.buf_index  = i_data[19:17];
        n_cmd.write_byte = i_data[27:20];
        n_cmd.too_long   = (i_data[16:9] > 8'(PAGE_BYTES));
        unique case (i_func)
            FUNC_TICK:  n_cmd.kind = KIND_TICK;
            FUNC_LOAD:  n_cmd.kind = KIND_LOAD;
            FUNC_WRITE: n_cmd.kind = KIND_WRITE;
            FUNC_READ:  n_cmd.kind = KIND_READ;
        endcase
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ----- hdl/i2cem_queue.sv -----
// ---------------------------------------------------------------------------
// i2cem_queue
// Short queue of classified items between the front and the sequencer.
// ---------------------------------------------------------------------------
module i2cem_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_ready,
    input  i2cem_pkg::t_cmd i_cmd,
    output logic            o_valid,
    input  logic            i_pop,
    output i2cem_pkg::t_cmd o_cmd
);
    import i2cem_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- hdl/i2cem_seq.sv -----
// ---------------------------------------------------------------------------
// i2cem_seq
// Bus sequencer: one half bit period per tick item, result register out.
// ---------------------------------------------------------------------------
module i2cem_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  i2cem_pkg::t_cfg_wr i_cfg,
    input  logic               i_valid,
    output logic               o_pop,
    input  i2cem_pkg::t_cmd    i_cmd,
    output logic               o_valid,
    input  logic               i_ready,
    output i2cem_pkg::t_res    o_res
);
    import i2cem_pkg::*;

    logic [7:0]           r_dev_wr;
    logic [7:0]           r_dev_rd;
    t_phase               r_phase,      n_phase;
    logic [1:0]           r_half,       n_half;
    logic [3:0]           r_bit_cnt,    n_bit_cnt;
    logic [7:0]           r_shift,      n_shift;
    logic [7:0]           r_byte_cnt,   n_byte_cnt;
    logic [7:0]           r_target,     n_target;
    logic [7:0]           r_start_addr, n_start_addr;
    logic                 r_is_read,    n_is_read;
    t_stage               r_stage,      n_stage;
    t_err                 r_pend_err,   n_pend_err;
    logic                 r_scl,        n_scl;
    logic                 r_sda,        n_sda;
    logic [7:0]           r_wbuf [BUF_SLOTS];
    logic                 r_out_valid;
    t_res                 r_out,        n_out;
    logic                 step;
    logic                 wbuf_we;
    logic [BUF_IDX_W-1:0] rd_idx;
    logic [7:0]           rd_byte;
    logic [7:0]           byte_inc;

    assign o_pop    = !r_out_valid || i_ready;
    assign step     = o_pop && i_valid;
    assign o_valid  = r_out_valid;
    assign o_res    = r_out;
    assign byte_inc = r_byte_cnt + 8'd1;
    assign rd_idx   = (r_stage == ST_MEM) ? '0 : byte_inc[BUF_IDX_W-1:0];
    assign rd_byte  = r_wbuf[rd_idx];
    assign wbuf_we  = step && (r_phase == PH_IDLE) && (i_cmd.kind == KIND_LOAD);

    always_comb begin
        n_phase      = r_phase;
        n_half       = r_half;
        n_bit_cnt    = r_bit_cnt;
        n_shift      = r_shift;
        n_byte_cnt   = r_byte_cnt;
        n_target     = r_target;
        n_start_addr = r_start_addr;
        n_is_read    = r_is_read;
        n_stage      = r_stage;
        n_pend_err   = r_pend_err;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_out        = '0;

        if (r_phase == PH_IDLE) begin
            if (i_cmd.kind == KIND_WRITE && i_cmd.too_long) begin
                n_out.done_res   = 1'b1;
                n_out.error_code = ERR_TOO_LONG;
            end else if (i_cmd.kind == KIND_WRITE || i_cmd.kind == KIND_READ) begin
                n_start_addr = i_cmd.mem_addr;
                n_target     = i_cmd.length;
                n_is_read    = (i_cmd.kind == KIND_READ);
                n_stage      = ST_DEVW;
                n_pend_err   = ERR_OK;
                n_byte_cnt   = '0;
                n_phase      = PH_START;
                n_half       = '0;
            end
        end else if (i_cmd.kind == KIND_TICK) begin
            unique case (r_phase)
                PH_START: begin
                    if (r_half == 2'd0) begin
                        n_scl = 1'b1; n_sda = 1'b1; n_half = 2'd1;
                    end else if (r_half == 2'd1) begin
                        n_scl = 1'b1; n_sda = 1'b0; n_half = 2'd2;
                    end else begin
                        n_scl     = 1'b0; n_sda = 1'b0;
                        n_phase   = PH_SEND;
                        n_half    = '0;
                        n_bit_cnt = '0;
                        n_shift   = (r_stage == ST_DEVR) ? r_dev_rd : r_dev_wr;
                    end
                end
                PH_RESTART: begin
                    n_scl   = 1'b0; n_sda = 1'b1;
                    n_phase = PH_START;
                    n_half  = '0;
                end
                PH_SEND: begin
                    n_sda = r_shift[7];
                    if (r_half == 2'd0) begin
                        n_scl  = 1'b0;
                        n_half = 2'd1;
                    end else begin
                        n_scl     = 1'b1;
                        n_half    = '0;
                        n_shift   = {r_shift[6:0], 1'b0};
                        n_bit_cnt = r_bit_cnt + 4'd1;
                        if (r_bit_cnt == 4'd7) begin
                            n_phase = PH_RACK;
                        end
                    end
                end
                PH_RACK: begin
                    n_sda = 1'b1;
                    if (r_half == 2'd0) begin
                        n_scl  = 1'b0;
                        n_half = 2'd1;
                    end else begin
                        n_scl  = 1'b1;
                        n_half = '0;
                        // prepare a byte send; overridden below where not wanted
                        n_bit_cnt = '0;
                        priority if (i_cmd.sda_in) begin
                            n_pend_err = nack_err(r_stage);
                            n_phase    = PH_STOP;
                        end else if (r_stage == ST_DEVW) begin
                            n_stage = ST_MEM;
                            n_phase = PH_SEND;
                            n_shift = r_start_addr;
                        end else if (r_stage == ST_MEM) begin
                            priority if (r_is_read) begin
                                n_stage = ST_DEVR;
                                n_phase = PH_RESTART;
                            end else if (r_target == 8'd0) begin
                                n_phase = PH_STOP;
                            end else begin
                                n_stage    = ST_DATA;
                                n_byte_cnt = '0;
                                n_phase    = PH_SEND;
                                n_shift    = rd_byte;
                            end
                        end else if (r_stage == ST_DATA) begin
                            n_byte_cnt = byte_inc;
                            if (byte_inc == r_target) begin
                                n_phase = PH_STOP;
                            end else begin
                                n_phase = PH_SEND;
                                n_shift = rd_byte;
                            end
                        end else begin
                            n_byte_cnt = '0;
                            if (r_target == 8'd0) begin
                                n_phase = PH_STOP;
                            end else begin
                                n_phase = PH_RECV;
                                n_shift = '0;
                            end
                        end
                    end
                end
                PH_RECV: begin
                    n_sda = 1'b1;
                    if (r_half == 2'd0) begin
                        n_scl  = 1'b0;
                        n_half = 2'd1;
                    end else begin
                        n_scl     = 1'b1;
                        n_half    = '0;
                        n_shift   = {r_shift[6:0], i_cmd.sda_in};
                        n_bit_cnt = r_bit_cnt + 4'd1;
                        if (r_bit_cnt == 4'd7) begin
                            n_out.read_data  = {r_shift[6:0], i_cmd.sda_in};
                            n_out.read_valid = 1'b1;
                            n_out.last_read  = (byte_inc == r_target);
                            n_phase          = PH_MACK;
                        end
                    end
                end
                PH_MACK: begin
                    n_sda = (byte_inc == r_target);
                    if (r_half == 2'd0) begin
                        n_scl  = 1'b0;
                        n_half = 2'd1;
                    end else begin
                        n_scl      = 1'b1;
                        n_half     = '0;
                        n_byte_cnt = byte_inc;
                        if (byte_inc == r_target) begin
                            n_phase = PH_STOP;
                        end else begin
                            n_phase   = PH_RECV;
                            n_bit_cnt = '0;
                            n_shift   = '0;
                        end
                    end
                end
                PH_STOP: begin
                    if (r_half == 2'd0) begin
                        n_scl = 1'b0; n_sda = 1'b0; n_half = 2'd1;
                    end else if (r_half == 2'd1) begin
                        n_scl = 1'b1; n_sda = 1'b0; n_half = 2'd2;
                    end else begin
                        n_scl            = 1'b1; n_sda = 1'b1;
                        n_out.done_res   = 1'b1;
                        n_out.error_code = r_pend_err;
                        n_phase          = PH_IDLE;
                        n_half           = '0;
                    end
                end
                PH_IDLE: begin
                    n_scl = 1'b1;
                    n_sda = 1'b1;
                end
            endcase
        end

        n_out.scl_level = n_scl;
        n_out.sda_level = n_sda;
        n_out.busy_res  = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_wr     <= DEV_WR_ADDR_RST;
            r_dev_rd     <= DEV_RD_ADDR_RST;
            r_phase      <= PH_IDLE;
            r_half       <= '0;
            r_bit_cnt    <= '0;
            r_shift      <= '0;
            r_byte_cnt   <= '0;
            r_target     <= '0;
            r_start_addr <= '0;
            r_is_read    <= 1'b0;
            r_stage      <= ST_DEVW;
            r_pend_err   <= ERR_OK;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.index == CFG_DEV_WR) begin
                r_dev_wr <= i_cfg.data;
            end
            if (i_cfg.valid && i_cfg.index == CFG_DEV_RD) begin
                r_dev_rd <= i_cfg.data;
            end
            if (step) begin
                r_phase      <= n_phase;
                r_half       <= n_half;
                r_bit_cnt    <= n_bit_cnt;
                r_shift      <= n_shift;
                r_byte_cnt   <= n_byte_cnt;
                r_target     <= n_target;
                r_start_addr <= n_start_addr;
                r_is_read    <= n_is_read;
                r_stage      <= n_stage;
                r_pend_err   <= n_pend_err;
                r_scl        <= n_scl;
                r_sda        <= n_sda;
            end
            if (o_pop) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
        if (wbuf_we) begin
            r_wbuf[i_cmd.buf_index] <= i_cmd.write_byte;
        end
    end

    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_scl && r_sda)
        else $error("lines not released while idle");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> !r_out.busy_res && r_out.scl_level
                                          && r_out.sda_level)
        else $error("finished transaction still busy or lines held");

    a_err_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.done_res |-> r_out.error_code == ERR_OK)
        else $error("error code without completion");

    a_rx_scl_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.read_valid |-> r_out.scl_level && r_out.busy_res)
        else $error("received byte outside a read bit");

    a_bit_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_cnt <= 4'd8)
        else $error("bit counter overran");

endmodule

// ----- hdl/i2c_eeprom_master.sv -----
// ---------------------------------------------------------------------------
// i2c_eeprom_master
// I2C master for a small serial EEPROM: page write and random read.
// ---------------------------------------------------------------------------
// Each input item gives exactly one result item. Items are taken one per clock
// cycle and results follow in order through the decode register, the two-entry
// queue and the sequencer result register; the sequencer retires one item per
// cycle, so the sustained rate is one item per cycle whenever the result side
// keeps tready high. A tick item is one half bit period on the bus and
// moves the sequencer by one step; start and load items are honoured only
// while no transaction runs. Line levels in each result are the open-drain
// drive after that item (1 released). Write device and read device address
// bytes come from configuration registers 0 and 1 (reset 0xA0 and 0xA1);
// write them only while the block is idle. A page write longer than the page
// size returns at once with error code 5. A missing acknowledge ends the
// transaction with a stop and an error code naming the byte that failed.
// Sending a buffer slot never loaded since reset yields an undefined byte.
// ---------------------------------------------------------------------------
module i2c_eeprom_master (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [i2cem_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [7:0]                            i_cfg_data,
    // input items
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [0] sda_in, [8:1] mem_addr, [16:9] length, [19:17] buf_index,
    // [27:20] write_byte, [31:28] zero
    input  logic [i2cem_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // [1:0] func
    input  logic [1:0]                            i_s_axis_tuser,
    // result items
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // [0] scl_level, [1] sda_level, [2] busy_res, [10:3] read_data,
    // [11] read_valid, [12] done_res, [15:13] error_code
    output logic [i2cem_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // last_read
    output logic                                  o_m_axis_tlast
);
    import i2cem_pkg::*;

    t_cmd    front_cmd;
    t_cmd    queue_cmd;
    logic    front_valid;
    logic    queue_ready;
    logic    queue_valid;
    logic    seq_pop;
    t_res    res;
    t_cfg_wr cfg_wr;

    // configuration is always taken
    assign o_cfg_ready  = 1'b1;
    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    // decode and classify
    i2cem_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_func  (i_s_axis_tuser),
        .i_data  (i_s_axis_tdata),
        .o_valid (front_valid),
        .i_ready (queue_ready),
        .o_cmd   (front_cmd)
    );

    // decouple front from sequencer
    i2cem_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .o_ready (queue_ready),
        .i_cmd   (front_cmd),
        .o_valid (queue_valid),
        .i_pop   (seq_pop),
        .o_cmd   (queue_cmd)
    );

    // drive the bus sequence and hold the result until taken
    i2cem_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_wr),
        .i_valid (queue_valid),
        .o_pop   (seq_pop),
        .i_cmd   (queue_cmd),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (res)
    );

    assign o_m_axis_tdata = {res.error_code, res.done_res, res.read_valid,
                             res.read_data, res.busy_res, res.sda_level, res.scl_level};
    assign o_m_axis_tlast = res.last_read;

endmodule
